@@ src/itda_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itda_pkg
// Shared types, constants and the double-dabble step for the integer to
// decimal text converter.
// ----------------------------------------------------------------------------
package itda_pkg;

    localparam int unsigned BIN_W           = 32;
    localparam int unsigned DIGITS          = 10;
    localparam int unsigned BCD_W           = DIGITS * 4;
    localparam int unsigned DABBLE_STAGES   = 4;
    localparam int unsigned STEPS_PER_STAGE = BIN_W / DABBLE_STAGES;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    // word moving through the conversion pipeline
    typedef struct packed {
        logic               neg;
        logic [BCD_W-1:0]   bcd;
        logic [BIN_W-1:0]   bin;
    } t_dd;

    // one shift-and-add-3 step over all digits
    function automatic t_dd dabble_step(input t_dd x);
        t_dd y;
        y = x;
        for (int d = 0; d < DIGITS; d++) begin
            if (y.bcd[d*4 +: 4] >= 4'd5) begin
                y.bcd[d*4 +: 4] = y.bcd[d*4 +: 4] + 4'd3;
            end
        end
        {y.bcd, y.bin} = {y.bcd[BCD_W-2:0], y.bin, 1'b0};
        return y;
    endfunction

endpackage
`default_nettype wire

@@ src/itda_dabble.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itda_dabble
// One pipeline stage of the binary to BCD conversion: a fixed number of
// double-dabble steps followed by a register with its valid bit.
// ----------------------------------------------------------------------------
module itda_dabble (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire itda_pkg::t_dd i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output itda_pkg::t_dd      o_data
);

    logic          r_valid;
    itda_pkg::t_dd r_data;
    itda_pkg::t_dd n_data;

    always_comb begin
        n_data = i_data;
        for (int s = 0; s < itda_pkg::STEPS_PER_STAGE; s++) begin
            n_data = itda_pkg::dabble_step(n_data);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

@@ src/itda_serial.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itda_serial
// Character serializer: drops leading zeros, emits an optional minus sign
// and then the digits most significant first through an output register.
// ----------------------------------------------------------------------------
module itda_serial (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_neg,
    input  wire logic [itda_pkg::BCD_W-1:0] i_bcd,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [7:0]                      o_character,
    output logic                            o_last
);

    logic       r_busy;
    logic       r_sign;
    logic [3:0] r_idx;
    logic [3:0] r_dig [itda_pkg::DIGITS];
    logic       r_ov;
    logic [7:0] r_char;
    logic       r_last;

    logic       out_free;
    logic       emit;
    logic       emit_last;
    logic       load;
    logic [3:0] lead;
    logic [7:0] n_char;

    // highest nonzero digit; zero keeps a single digit
    always_comb begin
        lead = '0;
        for (int d = 0; d < itda_pkg::DIGITS; d++) begin
            if (i_bcd[d*4 +: 4] != 4'd0) begin
                lead = 4'(d);
            end
        end
    end

    assign out_free  = !r_ov || i_ready;
    assign emit      = r_busy && out_free;
    assign emit_last = emit && !r_sign && (r_idx == 4'd0);
    assign o_ready   = !r_busy || emit_last;
    assign load      = i_valid && o_ready;
    assign n_char    = r_sign ? itda_pkg::ASCII_MINUS
                              : itda_pkg::ASCII_ZERO + {4'd0, r_dig[r_idx]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sign <= 1'b0;
            r_idx  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (out_free) begin
                r_ov <= r_busy;
            end
            if (emit) begin
                if (r_sign) begin
                    r_sign <= 1'b0;
                end else if (r_idx == 4'd0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx - 4'd1;
                end
            end
            if (load) begin
                r_busy <= 1'b1;
                r_sign <= i_neg;
                r_idx  <= lead;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_char <= n_char;
            r_last <= !r_sign && (r_idx == 4'd0);
        end
        if (load) begin
            for (int d = 0; d < itda_pkg::DIGITS; d++) begin
                r_dig[d] <= i_bcd[d*4 +: 4];
            end
        end
    end

    assign o_valid     = r_ov;
    assign o_character = r_char;
    assign o_last      = r_last;

    a_sign_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sign |-> r_busy)
        else $error("sign pending without a number in hand");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < 4'(itda_pkg::DIGITS)))
        else $error("digit index out of range");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_busy)
        else $error("number taken but serializer idle");

    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_last) |-> (r_char != itda_pkg::ASCII_MINUS))
        else $error("minus sign flagged as last character");

endmodule
`default_nettype wire

@@ src/int_to_decimal_ascii.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, one character per word.
// ----------------------------------------------------------------------------
// Each input word is a signed 32-bit integer; the block returns its decimal
// text as a stream of ASCII words, most significant character first, with a
// leading '-' for negative values, no leading zeros, a single '0' for zero,
// and o_last set on the final digit. The most negative value comes out as
// "-2147483648". Numbers enter a register pipeline (magnitude, four
// stages of eight double-dabble steps each, and the serializer), so a new
// number can be taken every cycle until the pipeline fills. The serializer
// output emits one character per cycle while i_ready is high; a number of
// 1 to 11 characters holds it until its last character is taken, so the
// output rate sets the sustained throughput. An accepted number passes the
// magnitude, dabble and serializer registers before its first character
// appears. Both ports use valid/ready; a stalled output holds its word and
// backs up the pipeline without losing or repeating anything.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [7:0]              o_character,
    output logic                    o_last
);

    localparam int unsigned NST = itda_pkg::DABBLE_STAGES;

    // front stage: sign and magnitude
    logic          r_front_valid;
    itda_pkg::t_dd r_front;
    itda_pkg::t_dd n_front;
    logic          front_ready;

    // links between dabble stages; index 0 is the front stage output
    logic          st_valid [NST+1];
    logic          st_ready [NST+1];
    itda_pkg::t_dd st_data  [NST+1];

    always_comb begin
        n_front.neg = i_value[31];
        n_front.bcd = '0;
        n_front.bin = i_value[31] ? (~i_value + 32'sd1) : i_value;
    end

    assign front_ready = !r_front_valid || st_ready[0];
    assign o_ready     = front_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_valid <= 1'b0;
        end else if (front_ready) begin
            r_front_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (front_ready && i_valid) begin
            r_front <= n_front;
        end
    end

    assign st_valid[0] = r_front_valid;
    assign st_data[0]  = r_front;

    // binary to BCD, eight bits per stage
    for (genvar g = 0; g < NST; g++) begin : g_dabble
        itda_dabble u_dabble (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[g]),
            .o_ready (st_ready[g]),
            .i_data  (st_data[g]),
            .o_valid (st_valid[g+1]),
            .i_ready (st_ready[g+1]),
            .o_data  (st_data[g+1])
        );
    end

    // drop leading zeros and stream the characters out
    itda_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (st_valid[NST]),
        .o_ready     (st_ready[NST]),
        .i_neg       (st_data[NST].neg),
        .i_bcd       (st_data[NST].bcd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire
